// ===== sv/lrgd_pkg.sv =====
// Shared types, constants and helpers for the gradient descent trainer.
package lrgd_pkg;

    // Field and datapath widths
    localparam int X_W      = 24;
    localparam int P_W      = 32;
    localparam int SUM_W    = 64;
    localparam int MUL_W    = 33;
    localparam int PROD_W   = 66;
    localparam int CNT_W    = 16;
    localparam int LR_W     = 16;
    localparam int INV_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_LENGTH = 2'd2;

    // Configuration reset values
    localparam logic [CNT_W-1:0] EPOCH_LENGTH_RST   = 16'd1000;
    localparam logic [LR_W-1:0]  LEARN_RATE_RST     = 16'd655;
    localparam logic [INV_W-1:0] INVERSE_LENGTH_RST = 32'd4294967;

    // Q8.16 one, used as the bias input
    localparam logic signed [X_W-1:0] X_ONE = 24'sh010000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PRED,
        ST_ERR,
        ST_GRAD,
        ST_SQR,
        ST_DRAIN,
        ST_MSE_HI,
        ST_MSE_LO,
        ST_U_MAG,
        ST_U_F_HI,
        ST_U_F_LO,
        ST_U_M,
        ST_U_LR_HI,
        ST_U_LR_LO,
        ST_U_STEP,
        ST_U_APPLY,
        ST_OUT
    } state_t;

    // What the product register holds this cycle
    typedef enum logic [3:0] {
        TAG_NONE,
        TAG_PRED,
        TAG_GRAD,
        TAG_SQR,
        TAG_F_HI,
        TAG_F_LO,
        TAG_MSE_LO,
        TAG_LR_HI,
        TAG_LR_LO
    } tag_t;

    // Clamp a signed 64-bit value to signed 32 bits
    function automatic logic signed [P_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [P_W-1:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[P_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/lrgd_mul.sv =====
// Shared signed multiplier with a registered product.
module lrgd_mul (
    input  logic                                  aclk,
    input  logic signed [lrgd_pkg::MUL_W-1:0]     a,
    input  logic signed [lrgd_pkg::MUL_W-1:0]     b,
    output logic signed [lrgd_pkg::PROD_W-1:0]    p
);

    localparam int PW = lrgd_pkg::PROD_W;

    logic signed [lrgd_pkg::PROD_W-1:0] p_reg;

    // Register every product
    always_ff @(posedge aclk) begin
        p_reg <= PW'(a) * PW'(b);
    end

    assign p = p_reg;

endmodule

// ===== sv/linear_regression_gd_trainer_core.sv =====
// Top level: linear regression trainer with one shared multiplier under a sequencer.
// A training sample issues on the single multiplier FEATURES+1 predict products, then
// (after the error is formed) FEATURES+1 gradient products and one square, then drains.
// A sample that closes an epoch goes on to the mean and the weight update, and then any
// wait for the result register to free up. A restart beat clears the model and sums
// without starting a sample. aresetn (synchronous) clears weights, sums and
// control, and loads the register defaults.
module linear_regression_gd_trainer_core #(
    parameter int FEATURES = 3
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // feature_0 .. feature_{FEATURES-1}, label (24 bits each, lowest first)
    input  logic [(FEATURES+1)*lrgd_pkg::X_W-1:0]         s_tdata,
    // cmd
    input  logic [0:0]                                    s_tuser,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // weight_0 .. weight_{FEATURES-1}, bias_out, epoch_mse (32 bits each, lowest first)
    output logic [(FEATURES+2)*lrgd_pkg::P_W-1:0]         m_tdata,
    input  logic                                          cfg_we,
    input  logic [lrgd_pkg::CFG_IDX_W-1:0]                cfg_index,
    input  logic [lrgd_pkg::CFG_DATA_W-1:0]               cfg_data
);

    localparam int IW = $clog2(FEATURES + 1);
    localparam logic [IW-1:0] BIAS_IDX = IW'(FEATURES);
    localparam int XW = lrgd_pkg::X_W;
    localparam int PW = lrgd_pkg::P_W;
    localparam int SW = lrgd_pkg::SUM_W;
    localparam int MW = lrgd_pkg::MUL_W;

    lrgd_pkg::state_t state_reg, state_next;
    lrgd_pkg::tag_t   tag_reg, issue_tag;

    logic [IW-1:0]                cnt_reg;
    logic [IW-1:0]                idx_reg;
    logic signed [XW-1:0]         x_reg [FEATURES+1];
    logic signed [PW-1:0]         param_reg [FEATURES+1];
    logic signed [SW-1:0]         sum_reg [FEATURES+1];
    logic [SW-1:0]                loss_reg;
    logic [lrgd_pkg::CNT_W-1:0]   count_reg;
    logic [lrgd_pkg::CNT_W-1:0]   epoch_len_reg;
    logic [lrgd_pkg::LR_W-1:0]    lr_reg;
    logic [lrgd_pkg::INV_W-1:0]   inv_reg;

    logic signed [SW-1:0]         acc_reg;
    logic signed [PW-1:0]         e_reg;
    logic [SW-1:0]                t_reg;
    logic [SW-1:0]                m_reg;
    logic [SW-1:0]                step_reg;
    logic [SW-1:0]                mag_reg;
    logic                         neg_reg;
    logic [PW-1:0]                mse_reg;
    logic                         m_tvalid_reg;
    logic [(FEATURES+2)*PW-1:0]   m_tdata_reg;

    logic signed [MW-1:0]         mul_a, mul_b;
    logic signed [lrgd_pkg::PROD_W-1:0] prod;
    logic [SW-1:0]                prod64;
    logic signed [SW-1:0]         acc_next;
    logic signed [SW-1:0]         grad_term;
    logic [IW-1:0]                sum_rd_idx;
    logic signed [SW-1:0]         sum_rd;
    logic [SW-1:0]                mse_sum;
    logic signed [SW-1:0]         p_ext;
    logic signed [SW-1:0]         p_new;
    logic                         epoch_end;
    logic                         in_acc;
    logic                         restart;
    logic                         out_free;
    logic signed [SW-1:0]         label_ext;

    // Shared multiplier
    lrgd_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    assign prod64    = prod[SW-1:0];
    assign acc_next  = acc_reg + ((tag_reg == lrgd_pkg::TAG_PRED) ? $signed(prod64) : 64'sd0);
    assign grad_term = $signed({{16{prod64[SW-1]}}, prod64[SW-1:16]});
    assign sum_rd_idx = (state_reg == lrgd_pkg::ST_U_MAG) ? cnt_reg : idx_reg;
    assign sum_rd    = sum_reg[sum_rd_idx];
    assign mse_sum   = t_reg + {32'd0, prod64[SW-1:32]};
    assign p_ext     = SW'(param_reg[cnt_reg]);
    assign p_new     = neg_reg ? (p_ext + $signed(step_reg)) : (p_ext - $signed(step_reg));
    assign epoch_end = ({1'b0, count_reg} + 17'd1) >= {1'b0, epoch_len_reg};
    assign in_acc    = s_tvalid && s_tready;
    assign restart   = in_acc && s_tuser[0];
    assign out_free  = !m_tvalid_reg || m_tready;
    assign label_ext = SW'($signed(s_tdata[FEATURES*XW +: XW]));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lrgd_pkg::ST_IDLE: begin
                if (in_acc && !s_tuser[0]) state_next = lrgd_pkg::ST_PRED;
            end
            lrgd_pkg::ST_PRED: begin
                if (cnt_reg == BIAS_IDX) state_next = lrgd_pkg::ST_ERR;
            end
            lrgd_pkg::ST_ERR:    state_next = lrgd_pkg::ST_GRAD;
            lrgd_pkg::ST_GRAD: begin
                if (cnt_reg == BIAS_IDX) state_next = lrgd_pkg::ST_SQR;
            end
            lrgd_pkg::ST_SQR:    state_next = lrgd_pkg::ST_DRAIN;
            lrgd_pkg::ST_DRAIN: begin
                if (epoch_end) begin
                    state_next = lrgd_pkg::ST_MSE_HI;
                end else if (in_acc && !s_tuser[0]) begin
                    state_next = lrgd_pkg::ST_PRED;
                end else begin
                    state_next = lrgd_pkg::ST_IDLE;
                end
            end
            lrgd_pkg::ST_MSE_HI:  state_next = lrgd_pkg::ST_MSE_LO;
            lrgd_pkg::ST_MSE_LO:  state_next = lrgd_pkg::ST_U_MAG;
            lrgd_pkg::ST_U_MAG:   state_next = lrgd_pkg::ST_U_F_HI;
            lrgd_pkg::ST_U_F_HI:  state_next = lrgd_pkg::ST_U_F_LO;
            lrgd_pkg::ST_U_F_LO:  state_next = lrgd_pkg::ST_U_M;
            lrgd_pkg::ST_U_M:     state_next = lrgd_pkg::ST_U_LR_HI;
            lrgd_pkg::ST_U_LR_HI: state_next = lrgd_pkg::ST_U_LR_LO;
            lrgd_pkg::ST_U_LR_LO: state_next = lrgd_pkg::ST_U_STEP;
            lrgd_pkg::ST_U_STEP:  state_next = lrgd_pkg::ST_U_APPLY;
            lrgd_pkg::ST_U_APPLY: begin
                state_next = (cnt_reg == BIAS_IDX) ? lrgd_pkg::ST_OUT : lrgd_pkg::ST_U_MAG;
            end
            lrgd_pkg::ST_OUT: begin
                if (out_free) state_next = lrgd_pkg::ST_IDLE;
            end
            default: state_next = lrgd_pkg::ST_IDLE;
        endcase
    end

    // Multiplier operands, product tag and input ready
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        issue_tag = lrgd_pkg::TAG_NONE;
        s_tready  = 1'b0;
        case (state_reg)
            lrgd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            lrgd_pkg::ST_PRED: begin
                mul_a     = MW'(x_reg[cnt_reg]);
                mul_b     = MW'(param_reg[cnt_reg]);
                issue_tag = lrgd_pkg::TAG_PRED;
            end
            lrgd_pkg::ST_GRAD: begin
                mul_a     = MW'(e_reg);
                mul_b     = MW'(x_reg[cnt_reg]);
                issue_tag = lrgd_pkg::TAG_GRAD;
            end
            lrgd_pkg::ST_SQR: begin
                mul_a     = MW'(e_reg);
                mul_b     = MW'(e_reg);
                issue_tag = lrgd_pkg::TAG_SQR;
            end
            lrgd_pkg::ST_DRAIN: begin
                s_tready = !epoch_end;
            end
            lrgd_pkg::ST_MSE_HI: begin
                mul_a     = $signed({1'b0, loss_reg[SW-1:32]});
                mul_b     = $signed({1'b0, inv_reg});
                issue_tag = lrgd_pkg::TAG_F_HI;
            end
            lrgd_pkg::ST_MSE_LO: begin
                mul_a     = $signed({1'b0, loss_reg[31:0]});
                mul_b     = $signed({1'b0, inv_reg});
                issue_tag = lrgd_pkg::TAG_MSE_LO;
            end
            lrgd_pkg::ST_U_F_HI: begin
                mul_a     = $signed({1'b0, mag_reg[SW-1:32]});
                mul_b     = $signed({1'b0, inv_reg});
                issue_tag = lrgd_pkg::TAG_F_HI;
            end
            lrgd_pkg::ST_U_F_LO: begin
                mul_a     = $signed({1'b0, mag_reg[31:0]});
                mul_b     = $signed({1'b0, inv_reg});
                issue_tag = lrgd_pkg::TAG_F_LO;
            end
            lrgd_pkg::ST_U_LR_HI: begin
                mul_a     = $signed({1'b0, m_reg[SW-1:32]});
                mul_b     = $signed({17'd0, lr_reg});
                issue_tag = lrgd_pkg::TAG_LR_HI;
            end
            lrgd_pkg::ST_U_LR_LO: begin
                mul_a     = $signed({1'b0, m_reg[31:0]});
                mul_b     = $signed({17'd0, lr_reg});
                issue_tag = lrgd_pkg::TAG_LR_LO;
            end
            default: begin
                issue_tag = lrgd_pkg::TAG_NONE;
            end
        endcase
    end

    // Control, model state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lrgd_pkg::ST_IDLE;
            tag_reg       <= lrgd_pkg::TAG_NONE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            loss_reg      <= '0;
            count_reg     <= '0;
            epoch_len_reg <= lrgd_pkg::EPOCH_LENGTH_RST;
            lr_reg        <= lrgd_pkg::LEARN_RATE_RST;
            inv_reg       <= lrgd_pkg::INVERSE_LENGTH_RST;
            m_tvalid_reg  <= 1'b0;
            for (int j = 0; j <= FEATURES; j++) begin
                param_reg[j] <= '0;
                sum_reg[j]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            tag_reg   <= issue_tag;
            idx_reg   <= cnt_reg;

            // Step the product index
            case (state_reg)
                lrgd_pkg::ST_PRED,
                lrgd_pkg::ST_GRAD: cnt_reg <= (cnt_reg == BIAS_IDX) ? '0 : cnt_reg + 1'b1;
                lrgd_pkg::ST_U_APPLY: cnt_reg <= cnt_reg + 1'b1;
                lrgd_pkg::ST_IDLE,
                lrgd_pkg::ST_DRAIN,
                lrgd_pkg::ST_OUT: cnt_reg <= '0;
                default: cnt_reg <= cnt_reg;
            endcase

            // Fold products into the running sums
            if (tag_reg == lrgd_pkg::TAG_GRAD) begin
                sum_reg[idx_reg] <= sum_rd + grad_term;
            end
            if (tag_reg == lrgd_pkg::TAG_SQR) begin
                loss_reg <= loss_reg + {16'd0, prod64[SW-1:16]};
            end

            // Advance the sample count within the epoch
            if (state_reg == lrgd_pkg::ST_DRAIN && !epoch_end) begin
                count_reg <= count_reg + 1'b1;
            end

            // Write the updated weight or bias
            if (state_reg == lrgd_pkg::ST_U_APPLY) begin
                param_reg[cnt_reg] <= lrgd_pkg::sat32(p_new);
            end

            // Hand the result over and open a new epoch
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == lrgd_pkg::ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
                loss_reg     <= '0;
                count_reg    <= '0;
                for (int j = 0; j <= FEATURES; j++) begin
                    sum_reg[j] <= '0;
                end
            end

            // Restart drops the model and all sums
            if (restart) begin
                loss_reg  <= '0;
                count_reg <= '0;
                for (int j = 0; j <= FEATURES; j++) begin
                    param_reg[j] <= '0;
                    sum_reg[j]   <= '0;
                end
            end

            // Configuration writes
            if (cfg_we) begin
                case (cfg_index)
                    lrgd_pkg::REG_EPOCH_LENGTH:   epoch_len_reg <= cfg_data[lrgd_pkg::CNT_W-1:0];
                    lrgd_pkg::REG_LEARN_RATE:     lr_reg        <= cfg_data[lrgd_pkg::LR_W-1:0];
                    lrgd_pkg::REG_INVERSE_LENGTH: inv_reg       <= cfg_data[lrgd_pkg::INV_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        // Capture the sample; the bias input is a constant one
        if (in_acc) begin
            for (int j = 0; j < FEATURES; j++) begin
                x_reg[j] <= $signed(s_tdata[j*XW +: XW]);
            end
            x_reg[FEATURES] <= lrgd_pkg::X_ONE;
            acc_reg <= 64'sd0 - (label_ext <<< 16);
        end else begin
            acc_reg <= acc_next;
        end

        // Error from the finished prediction
        if (state_reg == lrgd_pkg::ST_ERR) begin
            e_reg <= lrgd_pkg::sat32($signed({{16{acc_next[SW-1]}}, acc_next[SW-1:16]}));
        end

        // Magnitude and sign of the sum under update
        if (state_reg == lrgd_pkg::ST_U_MAG) begin
            neg_reg <= sum_rd[SW-1];
            mag_reg <= sum_rd[SW-1] ? (64'd0 - sum_rd) : sum_rd;
        end

        // Scale chain stages
        case (tag_reg)
            lrgd_pkg::TAG_F_HI:   t_reg    <= prod64;
            lrgd_pkg::TAG_F_LO:   m_reg    <= {mse_sum[SW-2:0], 1'b0};
            lrgd_pkg::TAG_MSE_LO: mse_reg  <= (|mse_sum[SW-1:32]) ? '1 : mse_sum[31:0];
            lrgd_pkg::TAG_LR_HI:  t_reg    <= {prod64[SW-17:0], 16'd0};
            lrgd_pkg::TAG_LR_LO:  step_reg <= t_reg + {16'd0, prod64[SW-1:16]};
            default: ;
        endcase

        // Load the result beat
        if (state_reg == lrgd_pkg::ST_OUT && out_free) begin
            for (int j = 0; j <= FEATURES; j++) begin
                m_tdata_reg[j*PW +: PW] <= param_reg[j];
            end
            m_tdata_reg[(FEATURES+1)*PW +: PW] <= mse_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A result beat only appears out of the output state
    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == lrgd_pkg::ST_OUT))
        else $error("result beat raised outside the output state");

    // A restart leaves the epoch empty
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0]) |=> (count_reg == '0 && loss_reg == '0))
        else $error("restart did not clear the epoch");

    // Predict products are only folded while the prediction is being built
    a_pred_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        (tag_reg == lrgd_pkg::TAG_PRED) |->
            (state_reg == lrgd_pkg::ST_PRED || state_reg == lrgd_pkg::ST_ERR))
        else $error("predict product outside prediction");

    // The update walk never passes the bias entry
    a_update_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lrgd_pkg::ST_U_APPLY) |-> (cnt_reg <= BIAS_IDX))
        else $error("update index out of range");

endmodule

// ===== dv/linear_regression_gd_trainer_core_tb.sv =====
// Self-checking testbench for the gradient descent trainer: streams samples, predicts each epoch.
module linear_regression_gd_trainer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int X_W        = lrgd_pkg::X_W;
    localparam int P_W        = lrgd_pkg::P_W;
    localparam int SUM_W      = lrgd_pkg::SUM_W;
    localparam int CNT_W      = lrgd_pkg::CNT_W;
    localparam int LR_W       = lrgd_pkg::LR_W;
    localparam int INV_W      = lrgd_pkg::INV_W;
    localparam int CFG_IDX_W  = lrgd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = lrgd_pkg::CFG_DATA_W;

    localparam int NF          = 3;
    localparam int IN_W        = (NF + 1) * X_W;
    localparam int OUT_W       = (NF + 2) * P_W;
    localparam int SETTLE      = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 242;

    localparam logic CMD_TRAIN   = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [X_W-1:0] X_MAX = 24'h7FFFFF;
    localparam logic [X_W-1:0] X_MIN = 24'h800000;
    localparam logic [X_W-1:0] X_M1  = 24'hFFFFFF;

    // Index used to exercise writes beyond the register list
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    // feature_0, feature_1, feature_2, label (24 bits each)
    logic [IN_W-1:0]   s_tdata   = '0;
    // cmd
    logic [0:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    // weight_0, weight_1, weight_2, bias_out, epoch_mse (32 bits each)
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int  send_idle_pct = 0;
    int  stall_pct     = 0;
    bit  hold_req      = 1'b0;

    // Golden trainer state plus the queue of epoch results still owed by the block
    class epoch_scoreboard;
        int unsigned             epoch_len;
        logic [LR_W-1:0]         lrate;
        logic [INV_W-1:0]        inv_len;
        logic signed [P_W-1:0]   weight [NF];
        logic signed [P_W-1:0]   bias;
        logic signed [SUM_W-1:0] grad_sum [NF];
        logic signed [SUM_W-1:0] bias_sum;
        logic [SUM_W-1:0]        loss_sum;
        int unsigned             count;
        logic [OUT_W-1:0]        expected_epochs [$];
        int                      failures;

        function new();
            epoch_len = 32'(lrgd_pkg::EPOCH_LENGTH_RST);
            lrate     = lrgd_pkg::LEARN_RATE_RST;
            inv_len   = lrgd_pkg::INVERSE_LENGTH_RST;
            failures  = 0;
            restart();
        endfunction

        function void clear_sums();
            for (int j = 0; j < NF; j++) grad_sum[j] = '0;
            bias_sum = '0;
            loss_sum = '0;
            count    = 0;
        endfunction

        function void restart();
            for (int j = 0; j < NF; j++) weight[j] = '0;
            bias = '0;
            clear_sums();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                lrgd_pkg::REG_EPOCH_LENGTH:   epoch_len = 32'(val[CNT_W-1:0]);
                lrgd_pkg::REG_LEARN_RATE:     lrate     = val[LR_W-1:0];
                lrgd_pkg::REG_INVERSE_LENGTH: inv_len   = val[INV_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [P_W-1:0] clamp32(logic signed [SUM_W-1:0] v);
            if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[P_W-1:0];
        endfunction

        // floor(mag * f / 2^32), split in halves with 64-bit wrap
        function logic [SUM_W-1:0] scale_q32(logic [SUM_W-1:0] mag, logic [INV_W-1:0] f);
            logic [SUM_W-1:0] hi;
            logic [SUM_W-1:0] lo;
            hi = {32'd0, mag[63:32]} * {32'd0, f};
            lo = ({32'd0, mag[31:0]} * {32'd0, f}) >> 32;
            return hi + lo;
        endfunction

        // Move a parameter against the sign of its summed gradient
        function logic signed [P_W-1:0] descend(logic signed [P_W-1:0] p,
                                                logic signed [SUM_W-1:0] s);
            logic                    neg;
            logic [SUM_W-1:0]        mag;
            logic [SUM_W-1:0]        m;
            logic [SUM_W-1:0]        step;
            logic signed [SUM_W-1:0] p64;
            logic signed [SUM_W-1:0] np;
            neg  = s[SUM_W-1];
            mag  = neg ? 64'd0 - s : s;
            m    = scale_q32(mag, inv_len) << 1;
            step = (m >> 16) * {48'd0, lrate}
                 + (({48'd0, m[15:0]} * {48'd0, lrate}) >> 16);
            p64  = SUM_W'(p);
            np   = neg ? p64 + step : p64 - step;
            return clamp32(np);
        endfunction

        // Advance the trainer by one accepted beat
        function void note_beat(logic cmd, logic [IN_W-1:0] data);
            logic signed [SUM_W-1:0] xs [NF];
            logic signed [SUM_W-1:0] acc;
            logic signed [SUM_W-1:0] lab;
            logic signed [SUM_W-1:0] err;
            logic signed [SUM_W-1:0] w64;
            logic [SUM_W-1:0]        sq;
            logic [SUM_W-1:0]        mse;
            logic [OUT_W-1:0]        res;
            if (cmd == CMD_RESTART) begin
                restart();
                return;
            end
            acc = SUM_W'(bias);
            acc = acc <<< 16;
            for (int j = 0; j < NF; j++) begin
                xs[j] = SUM_W'($signed(data[j*X_W +: X_W]));
                w64   = SUM_W'(weight[j]);
                acc   = acc + xs[j] * w64;
            end
            lab = SUM_W'($signed(data[NF*X_W +: X_W]));
            acc = acc - (lab <<< 16);
            err = SUM_W'(clamp32(acc >>> 16));
            for (int j = 0; j < NF; j++) grad_sum[j] = grad_sum[j] + ((err * xs[j]) >>> 16);
            bias_sum = bias_sum + err;
            sq       = err * err;
            loss_sum = loss_sum + (sq >> 16);
            if (count + 1 < epoch_len) begin
                count++;
                return;
            end
            // Epoch complete: mean loss from the old sums, then update
            mse = scale_q32(loss_sum, inv_len);
            if (mse > 64'h00000000FFFFFFFF) mse = 64'h00000000FFFFFFFF;
            for (int j = 0; j < NF; j++) begin
                weight[j] = descend(weight[j], grad_sum[j]);
                res[j*P_W +: P_W] = weight[j];
            end
            bias = descend(bias, bias_sum);
            res[NF*P_W +: P_W]     = bias;
            res[(NF+1)*P_W +: P_W] = mse[P_W-1:0];
            expected_epochs.push_back(res);
            clear_sums();
        endfunction

        function string field_name(int k);
            if (k < NF) return $sformatf("weight_%0d", k);
            if (k == NF) return "bias_out";
            return "epoch_mse";
        endfunction

        function void flag(string what);
            failures++;
            if (failures <= 10) $display("[%0t] mismatch: %s", $time, what);
        endfunction

        // Compare one result beat against the oldest expected epoch
        function void check_epoch(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (expected_epochs.size() == 0) begin
                flag($sformatf("unexpected result %h", got));
                return;
            end
            want = expected_epochs.pop_front();
            for (int k = 0; k < NF + 2; k++) begin
                if (got[k*P_W +: P_W] !== want[k*P_W +: P_W])
                    flag($sformatf("%s expected %h got %h", field_name(k),
                                   want[k*P_W +: P_W], got[k*P_W +: P_W]));
            end
        endfunction

        function int pending();
            return expected_epochs.size();
        endfunction
    endclass

    epoch_scoreboard sb = new();

    linear_regression_gd_trainer_core #(.FEATURES(NF)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sample both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_beat(s_tuser[0], s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_epoch(m_tdata);
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    // Run limit
    initial begin
        #8ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Offer one beat, with random idle cycles ahead of it; returns at a falling edge
    task automatic send_beat(input logic cmd, input logic [IN_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = data;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Drain all owed results, then let the block finish any sample still in flight
    task automatic quiesce();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    function automatic logic [X_W-1:0] rand_field();
        int v;
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return X_MAX;
                    1: return X_MIN;
                    2: return '0;
                    default: return X_M1;
                endcase
            end
            1, 2: return X_W'($urandom);
            default: begin
                // Within +/-2.0, the realistic range
                v = $urandom_range(0, 262144);
                return X_W'(v - 131072);
            end
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_sample();
        return {rand_field(), rand_field(), rand_field(), rand_field()};
    endfunction

    // One configuration, then a stream of samples with occasional restarts
    task automatic run_random_phase(input bit single_epoch);
        int unsigned elen;
        logic [LR_W-1:0] lr;
        logic [INV_W-1:0] inv;
        quiesce();
        case ($urandom_range(3))
            0: elen = $urandom_range(1, 4);
            1: elen = $urandom_range(5, 12);
            2: elen = $urandom_range(13, 40);
            default: elen = $urandom_range(2, 6);
        endcase
        if (single_epoch) elen = 1;
        case ($urandom_range(3))
            0: lr = lrgd_pkg::LEARN_RATE_RST;
            1: lr = LR_W'($urandom);
            2: lr = 16'hFFFF;
            default: lr = LR_W'($urandom_range(100, 3000));
        endcase
        inv = ($urandom_range(3) == 0) ? $urandom : 32'hFFFFFFFF / elen;
        // Upper bits of the 16-bit registers carry junk
        write_reg(lrgd_pkg::REG_EPOCH_LENGTH, {16'($urandom_range(65535)), elen[15:0]});
        write_reg(lrgd_pkg::REG_LEARN_RATE, {16'($urandom_range(65535)), lr});
        write_reg(lrgd_pkg::REG_INVERSE_LENGTH, inv);
        if (single_epoch) hold_req = 1'b1;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(99) < 3) send_beat(CMD_RESTART, rand_sample());
            else send_beat(CMD_TRAIN, rand_sample());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Zero epoch length with steepest rate: every sample ends an epoch, weights saturate
        write_reg(lrgd_pkg::REG_EPOCH_LENGTH, 32'd0);
        write_reg(lrgd_pkg::REG_LEARN_RATE, 32'h0000FFFF);
        write_reg(lrgd_pkg::REG_INVERSE_LENGTH, 32'hFFFFFFFF);
        send_beat(CMD_TRAIN, {X_MIN, X_MAX, X_MAX, X_MAX});
        send_beat(CMD_TRAIN, {X_MAX, X_MIN, X_MIN, X_MIN});
        send_beat(CMD_TRAIN, {24'h0, 24'h0, 24'h0, 24'h0});
        send_beat(CMD_TRAIN, {X_MAX, X_MAX, X_MIN, X_MAX});
        send_beat(CMD_TRAIN, {X_M1, 24'h000001, X_M1, 24'h000001});
        // Restart ignores its payload
        send_beat(CMD_RESTART, {IN_W{1'b1}});
        send_beat(CMD_TRAIN, {24'h020000, lrgd_pkg::X_ONE, lrgd_pkg::X_ONE, lrgd_pkg::X_ONE});

        // Longest epoch, then shorten it mid-epoch
        quiesce();
        write_reg(lrgd_pkg::REG_EPOCH_LENGTH, 32'd65535);
        write_reg(lrgd_pkg::REG_LEARN_RATE, {16'd0, lrgd_pkg::LEARN_RATE_RST});
        write_reg(lrgd_pkg::REG_INVERSE_LENGTH, 32'd65537);
        send_beat(CMD_TRAIN, {24'h018000, 24'h008000, 24'hFF0000, lrgd_pkg::X_ONE});
        send_beat(CMD_TRAIN, {24'hFE8000, 24'h004000, lrgd_pkg::X_ONE, 24'h030000});
        send_beat(CMD_TRAIN, rand_sample());
        quiesce();
        write_reg(lrgd_pkg::REG_EPOCH_LENGTH, 32'd2);
        send_beat(CMD_TRAIN, rand_sample());

        // Zero rate and zero reciprocal: parameters hold, mean reads zero
        quiesce();
        write_reg(lrgd_pkg::REG_LEARN_RATE, 32'd0);
        write_reg(lrgd_pkg::REG_INVERSE_LENGTH, 32'd0);
        send_beat(CMD_TRAIN, {X_MAX, X_MAX, X_MAX, X_MAX});
        send_beat(CMD_TRAIN, {X_MIN, X_MIN, X_MIN, X_MIN});

        // Write past the register list; nothing may change
        quiesce();
        write_reg(REG_UNUSED, 32'hFFFFFFFF);
        send_beat(CMD_TRAIN, rand_sample());
        send_beat(CMD_TRAIN, rand_sample());
        send_beat(CMD_RESTART, '0);

        // Random part across the idle patterns, two settings each
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 65; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 65; end
                default: begin send_idle_pct = 23; stall_pct = 23; end
            endcase
            run_random_phase(ph == 0);
            run_random_phase(1'b0);
        end

        quiesce();
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
